FILE: rtl/utf8s_pkg.sv
// ============================================================================
// utf8s_pkg
// Types, constants and sequence checks shared by the UTF-8 sanitizer files.
// ============================================================================
`default_nettype none

package utf8s_pkg;

	typedef logic [7:0] byte_t;

	typedef enum logic [1:0] {
		STATUS_CLEAN    = 2'd0,
		STATUS_REPLACED = 2'd1,
		STATUS_NUL      = 2'd2
	} status_t;

	// One queued output beat.
	typedef struct packed {
		byte_t   data;
		logic    last;
		status_t status;
	} result_t;

	localparam byte_t QMARK        = 8'h3F;
	localparam byte_t MIN_LEAD2    = 8'hC2;
	localparam byte_t LEAD_E0      = 8'hE0;
	localparam byte_t LEAD_ED      = 8'hED;
	localparam byte_t LEAD_F0      = 8'hF0;
	localparam byte_t LEAD_F4      = 8'hF4;
	localparam byte_t E0_MIN_CONT  = 8'hA0;
	localparam byte_t ED_MAX_CONT  = 8'h9F;
	localparam byte_t F0_MIN_CONT  = 8'h90;
	localparam byte_t F4_MAX_CONT  = 8'h8F;
	localparam byte_t ASCII_LIMIT  = 8'h80;

	localparam int QDEPTH = 8;
	localparam int QAW    = $clog2(QDEPTH);
	// Processing needs room for a full group of four results.
	localparam int MAX_GROUP = 4;

	function automatic logic is_cont(input byte_t b);
		is_cont = (b[7:6] == 2'b10);
	endfunction

	// Expected sequence length of a lead byte: 2, 3, 4, or 0 if not a lead.
	function automatic logic [2:0] seq_len(input byte_t c0);
		logic [2:0] len;
		len = 3'd0;
		if (c0[7:5] == 3'b110)
			len = 3'd2;
		else if (c0[7:4] == 4'b1110)
			len = 3'd3;
		else if (c0[7:3] == 5'b11110)
			len = 3'd4;
		seq_len = len;
	endfunction

	// All len bytes of the candidate sequence are present in b0..b3.
	function automatic logic seq_valid(input byte_t b0, input byte_t b1,
			input byte_t b2, input byte_t b3, input logic [2:0] len);
		logic ok;
		ok = is_cont(b1);
		if (len == 3'd2) begin
			ok = ok && (b0 >= MIN_LEAD2);
		end else if (len == 3'd3) begin
			ok = ok && is_cont(b2)
				&& !(b0 == LEAD_E0 && b1 < E0_MIN_CONT)
				&& !(b0 == LEAD_ED && b1 > ED_MAX_CONT);
		end else begin
			ok = ok && is_cont(b2) && is_cont(b3) && (b0 <= LEAD_F4)
				&& !(b0 == LEAD_F0 && b1 < F0_MIN_CONT)
				&& !(b0 == LEAD_F4 && b1 > F4_MAX_CONT);
		end
		seq_valid = ok;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/utf8s_in_if.sv
// ============================================================================
// utf8s_in_if
// Raw byte channel into the sanitizer: one byte and its record-end mark.
// ============================================================================
`default_nettype none

interface utf8s_in_if;
	logic               valid;
	logic               ready;
	utf8s_pkg::byte_t   in_byte;
	logic               end_of_record;

	modport source (output valid, output in_byte, output end_of_record, input ready);
	modport sink (input valid, input in_byte, input end_of_record, output ready);
endinterface

`default_nettype wire

FILE: rtl/utf8s_out_if.sv
// ============================================================================
// utf8s_out_if
// Sanitized byte channel out of the sanitizer, with record status.
// ============================================================================
`default_nettype none

interface utf8s_out_if;
	logic               valid;
	logic               ready;
	utf8s_pkg::byte_t   out_byte;
	logic               out_last;
	logic [1:0]         record_status;

	modport source (output valid, output out_byte, output out_last,
		output record_status, input ready);
	modport sink (input valid, input out_byte, input out_last,
		input record_status, output ready);
endinterface

`default_nettype wire

FILE: rtl/utf8_sanitizer.sv
// ============================================================================
// utf8_sanitizer
// Streaming UTF-8 validator that replaces bad bytes with '?'.
// ============================================================================
//
//  channel | dir | beat payload
//  --------+-----+-------------------------------------------
//  raw     | in  | in_byte, end_of_record
//  clean   | out | out_byte, out_last, record_status
//
// One byte is taken per cycle while decision is not stalled. A beat is registered,
// then decided against up to three held bytes, producing zero to four result beats
// into an eight-entry output queue that drains one beat per cycle while the
// clean side is ready. A lead byte stays held until its sequence is complete or
// the record ends. Decision stalls while more than four beats wait in the queue.
// Reset clears the held count, the record flags and the queue.
`default_nettype none

module utf8_sanitizer (
	input  wire              clk,
	input  wire              arst_n,
	utf8s_in_if.sink         raw,
	utf8s_out_if.source      clean
);

	// Input register.
	logic                      valid_s1;
	utf8s_pkg::byte_t          byte_s1;
	logic                      last_s1;

	// Record state.
	utf8s_pkg::byte_t          held_q [3];
	logic [1:0]                held_cnt_q;
	logic                      rep_q;
	logic                      nul_q;

	// Output queue.
	utf8s_pkg::result_t        queue_q [utf8s_pkg::QDEPTH];
	logic [utf8s_pkg::QAW-1:0] wr_ptr_q;
	logic [utf8s_pkg::QAW-1:0] rd_ptr_q;
	logic [utf8s_pkg::QAW:0]   count_q;

	// Decision logic.
	utf8s_pkg::byte_t          win [4];
	utf8s_pkg::byte_t          res [4];
	utf8s_pkg::byte_t          held_d [3];
	utf8s_pkg::byte_t          c0;
	logic [2:0]                n;
	logic [2:0]                p;
	logic [2:0]                k;
	logic [2:0]                len;
	logic [1:0]                idx;
	logic                      stop;
	logic                      nul_v;
	logic                      rep_v;
	utf8s_pkg::status_t        status_v;

	logic                      proc;
	logic                      pop;

	assign proc      = valid_s1 && (count_q <= (utf8s_pkg::QAW+1)'(utf8s_pkg::QDEPTH
		- utf8s_pkg::MAX_GROUP));
	assign pop       = clean.valid && clean.ready;
	assign raw.ready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (raw.ready) begin
			valid_s1 <= raw.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (raw.ready && raw.valid) begin
			byte_s1 <= raw.in_byte;
			last_s1 <= raw.end_of_record;
		end
	end

	// Walk the window of held bytes plus the new one, deciding as many bytes
	// as possible. Each pass decides at least one byte or stops.
	always_comb begin
		n = {1'b0, held_cnt_q} + 3'd1;
		for (int j = 0; j < 3; j++) begin
			win[j] = (2'(j) < held_cnt_q) ? held_q[j] : byte_s1;
		end
		win[3] = byte_s1;

		p     = 3'd0;
		k     = 3'd0;
		stop  = 1'b0;
		nul_v = nul_q;
		rep_v = rep_q;
		c0    = '0;
		len   = 3'd0;
		idx   = 2'd0;
		for (int j = 0; j < 4; j++) begin
			res[j] = '0;
		end

		for (int it = 0; it < 4; it++) begin
			if (!stop && p < n) begin
				c0  = win[p[1:0]];
				len = utf8s_pkg::seq_len(c0);
				if (nul_v || c0 < utf8s_pkg::ASCII_LIMIT) begin
					if (c0 == '0) begin
						nul_v = 1'b1;
					end
					res[k[1:0]] = c0;
					k = k + 3'd1;
					p = p + 3'd1;
				end else if (len != 3'd0 && p + len > n && !last_s1) begin
					stop = 1'b1;
				end else if (len != 3'd0 && p + len <= n
						&& utf8s_pkg::seq_valid(win[p[1:0]], win[2'(p + 3'd1)],
						win[2'(p + 3'd2)], win[2'(p + 3'd3)], len)) begin
					for (int q = 0; q < 4; q++) begin
						if (3'(q) < len) begin
							idx = 2'(k + 3'(q));
							res[idx] = win[2'(p + 3'(q))];
						end
					end
					k = k + len;
					p = p + len;
				end else begin
					res[k[1:0]] = utf8s_pkg::QMARK;
					rep_v = 1'b1;
					k = k + 3'd1;
					p = p + 3'd1;
				end
			end
		end

		for (int j = 0; j < 3; j++) begin
			held_d[j] = win[2'(p + 3'(j))];
		end

		if (nul_v) begin
			status_v = utf8s_pkg::STATUS_NUL;
		end else if (rep_v) begin
			status_v = utf8s_pkg::STATUS_REPLACED;
		end else begin
			status_v = utf8s_pkg::STATUS_CLEAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
			rep_q      <= 1'b0;
			nul_q      <= 1'b0;
		end else if (proc) begin
			if (last_s1) begin
				held_cnt_q <= 2'd0;
				rep_q      <= 1'b0;
				nul_q      <= 1'b0;
			end else begin
				held_cnt_q <= 2'(n - p);
				rep_q      <= rep_v;
				nul_q      <= nul_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			for (int j = 0; j < 3; j++) begin
				held_q[j] <= held_d[j];
			end
		end
	end

	// Queue writes: one entry per decided byte, status only on the record end.
	always_ff @(posedge clk) begin
		if (proc) begin
			for (int j = 0; j < 4; j++) begin
				if (3'(j) < k) begin
					queue_q[wr_ptr_q + utf8s_pkg::QAW'(j)].data <= res[j];
					if (last_s1 && 3'(j) == k - 3'd1) begin
						queue_q[wr_ptr_q + utf8s_pkg::QAW'(j)].last   <= 1'b1;
						queue_q[wr_ptr_q + utf8s_pkg::QAW'(j)].status <= status_v;
					end else begin
						queue_q[wr_ptr_q + utf8s_pkg::QAW'(j)].last   <= 1'b0;
						queue_q[wr_ptr_q + utf8s_pkg::QAW'(j)].status <=
							utf8s_pkg::STATUS_CLEAN;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (proc) begin
				wr_ptr_q <= wr_ptr_q + utf8s_pkg::QAW'(k);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + utf8s_pkg::QAW'(1);
			end
			count_q <= count_q + (proc ? (utf8s_pkg::QAW+1)'(k) : '0)
				- (pop ? (utf8s_pkg::QAW+1)'(1) : '0);
		end
	end

	assign clean.valid         = (count_q != '0);
	assign clean.out_byte      = queue_q[rd_ptr_q].data;
	assign clean.out_last      = queue_q[rd_ptr_q].last;
	assign clean.record_status = queue_q[rd_ptr_q].status;

endmodule

`default_nettype wire

FILE: tb/sv/utf8s_sb_pkg.sv
// ============================================================================
// utf8s_sb_pkg
// Scoreboard for the UTF-8 sanitizer: predicts clean beats from raw beats.
// ============================================================================
`default_nettype none

package utf8s_sb_pkg;

	import utf8s_pkg::*;

	class utf8_scoreboard;
		byte_t       held_bytes[3];
		int unsigned held_count;
		bit          replaced_seen;
		bit          nul_seen;
		result_t     pending_beats[$];
		int unsigned errors;

		function new();
			held_count    = 0;
			replaced_seen = 1'b0;
			nul_seen      = 1'b0;
			errors        = 0;
		endfunction

		static function bit cont_byte(byte_t c);
			return c >= 8'h80 && c <= 8'hBF;
		endfunction

		static function int lead_length(byte_t c);
			if (c >= 8'hC0 && c <= 8'hDF)
				return 2;
			if (c >= 8'hE0 && c <= 8'hEF)
				return 3;
			if (c >= 8'hF0 && c <= 8'hF7)
				return 4;
			return 0;
		endfunction

		// Only the first len bytes matter; the rest may be stale.
		static function bit well_formed(byte_t c0, byte_t c1, byte_t c2, byte_t c3,
				int len);
			if (!cont_byte(c1))
				return 1'b0;
			if (len == 2)
				return c0 >= MIN_LEAD2;
			if (!cont_byte(c2))
				return 1'b0;
			if (len == 3)
				return !(c0 == LEAD_E0 && c1 < E0_MIN_CONT)
					&& !(c0 == LEAD_ED && c1 > ED_MAX_CONT);
			return cont_byte(c3) && c0 <= LEAD_F4
				&& !(c0 == LEAD_F0 && c1 < F0_MIN_CONT)
				&& !(c0 == LEAD_F4 && c1 > F4_MAX_CONT);
		endfunction

		static function result_t plain_beat(byte_t d);
			result_t r;
			r.data   = d;
			r.last   = 1'b0;
			r.status = STATUS_CLEAN;
			return r;
		endfunction

		// Appends the raw byte to the held bytes and decides all that can be.
		function void note_raw_beat(byte_t b, logic eor);
			byte_t   w[8];
			int      n;
			int      p;
			int      len;
			int      i;
			result_t r;
			result_t decided[$];
			n = held_count;
			for (i = 0; i < n; i++)
				w[i] = held_bytes[i];
			w[n] = b;
			n++;
			p = 0;
			while (p < n) begin
				if (nul_seen || w[p] < ASCII_LIMIT) begin
					if (w[p] == 8'h00)
						nul_seen = 1'b1;
					decided.push_back(plain_beat(w[p]));
					p++;
				end else begin
					len = lead_length(w[p]);
					// A lead byte waits for its whole sequence unless the record ends.
					if (len != 0 && p + len > n && !eor)
						break;
					if (len != 0 && p + len <= n
							&& well_formed(w[p], w[p+1], w[p+2], w[p+3], len)) begin
						for (i = 0; i < len; i++)
							decided.push_back(plain_beat(w[p+i]));
						p += len;
					end else begin
						decided.push_back(plain_beat(QMARK));
						replaced_seen = 1'b1;
						p++;
					end
				end
			end
			held_count = n - p;
			for (i = 0; i < held_count; i++)
				held_bytes[i] = w[p+i];
			if (eor) begin
				r = decided.pop_back();
				r.last = 1'b1;
				if (nul_seen)
					r.status = STATUS_NUL;
				else if (replaced_seen)
					r.status = STATUS_REPLACED;
				decided.push_back(r);
				replaced_seen = 1'b0;
				nul_seen      = 1'b0;
				held_count    = 0;
			end
			foreach (decided[i])
				pending_beats.push_back(decided[i]);
		endfunction

		task report(string what);
			$display("ERROR: %s", what);
			errors++;
		endtask

		task check_clean_beat(byte_t data, logic last, logic [1:0] status);
			result_t want;
			if (pending_beats.size() == 0) begin
				report($sformatf("clean beat %h with nothing expected", data));
				return;
			end
			want = pending_beats.pop_front();
			if (data !== want.data)
				report($sformatf("out_byte %h, want %h", data, want.data));
			if (last !== want.last)
				report($sformatf("out_last %b, want %b (byte %h)", last, want.last,
					want.data));
			if (status !== want.status)
				report($sformatf("record_status %0d, want %0d (byte %h)", status,
					want.status, want.data));
		endtask

		function int pending();
			return pending_beats.size();
		endfunction
	endclass

endpackage

`default_nettype wire

FILE: tb/sv/testbench.sv
// ============================================================================
// testbench
// Drives byte records into utf8_sanitizer and checks every clean beat.
// Directed records cover the boundaries of each sequence form, then random
// records of mostly well-formed text with noise, under random stalls on both
// sides, one long output hold-off and one full drain.
// ============================================================================
`default_nettype none

module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import utf8s_pkg::*;
	import utf8s_sb_pkg::*;

	localparam int ITEM_TARGET = 310;
	localparam int HOLD_CYCLES = 150;
	localparam int IDLE_PCT    = 36;

	logic clk;
	logic arst_n;

	utf8s_in_if  raw_ch ();
	utf8s_out_if clean_ch ();

	utf8_sanitizer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw_ch),
		.clean  (clean_ch)
	);

	utf8_scoreboard sb;
	byte_t          record_bytes[$];
	int unsigned    items_sent;
	bit             no_idle;
	bit             hold_go;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#400_000;
		$display("Some tests failed");
		$finish;
	end

	// Output side: random ready, with one long hold-off on request.
	initial begin
		clean_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go) begin
				clean_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_go = 1'b0;
			end else begin
				clean_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && clean_ch.valid && clean_ch.ready)
			sb.check_clean_beat(clean_ch.out_byte, clean_ch.out_last,
				clean_ch.record_status);
	end

	task automatic send_byte(input byte_t b, input logic eor);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			raw_ch.valid <= 1'b0;
			@(negedge clk);
		end
		raw_ch.valid         <= 1'b1;
		raw_ch.in_byte       <= b;
		raw_ch.end_of_record <= eor;
		do
			@(posedge clk);
		while (!raw_ch.ready);
		sb.note_raw_beat(b, eor);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_record();
		foreach (record_bytes[i])
			send_byte(record_bytes[i], i == record_bytes.size() - 1);
	endtask

	task automatic wait_drained();
		raw_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	// Random record: mostly valid code points, some noise, cut sequences and NULs.
	task automatic build_record();
		int         tokens;
		int         pick;
		int         keep;
		logic [20:0] cp;
		byte_t      seq[$];
		record_bytes.delete();
		tokens = $urandom_range(10, 1);
		repeat (tokens) begin
			seq.delete();
			pick = $urandom_range(99);
			if (pick < 30) begin
				seq.push_back(byte_t'($urandom_range(8'h7F, 8'h01)));
			end else if (pick < 48) begin
				cp = 21'($urandom_range(21'h7FF, 21'h80));
				seq = '{{3'b110, cp[10:6]}, {2'b10, cp[5:0]}};
			end else if (pick < 66) begin
				cp = 21'($urandom_range(21'hFFFF, 21'h800));
				if (cp >= 21'hD800 && cp <= 21'hDFFF)
					cp = cp ^ 21'h4000;
				seq = '{{4'b1110, cp[15:12]}, {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
			end else if (pick < 78) begin
				cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
				seq = '{{5'b11110, cp[20:18]}, {2'b10, cp[17:12]},
					{2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
			end else if (pick < 90) begin
				seq.push_back(byte_t'($urandom_range(255)));
			end else if (pick < 98) begin
				// A sequence cut short before its last continuation byte.
				cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
				seq = '{{5'b11110, cp[20:18]}, {2'b10, cp[17:12]},
					{2'b10, cp[11:6]}};
				keep = $urandom_range(3, 1);
				while (seq.size() > keep)
					void'(seq.pop_back());
			end else begin
				seq.push_back(8'h00);
			end
			foreach (seq[i])
				record_bytes.push_back(seq[i]);
		end
	endtask

	initial begin
		int rec_idx;
		sb                   = new();
		items_sent           = 0;
		no_idle              = 1'b0;
		hold_go              = 1'b0;
		arst_n               = 1'b0;
		raw_ch.valid         = 1'b0;
		raw_ch.in_byte       = 8'h00;
		raw_ch.end_of_record = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Plain ASCII only.
		record_bytes = '{8'h41, 8'h7F};
		send_record();
		// Overlong two-byte, overlong three-byte, surrogate, above the top code point.
		record_bytes = '{8'hC1, 8'h80, 8'hE0, 8'h9F, 8'h80, 8'hED, 8'hA0, 8'hBF,
			8'hF4, 8'h90, 8'h80, 8'h80};
		send_record();
		// Smallest four-byte form, a lead above F4, bad leads, then a cut sequence.
		record_bytes = '{8'hF0, 8'h90, 8'h80, 8'h80, 8'hF5, 8'h80, 8'hFF, 8'hE2, 8'h82};
		send_record();
		// A waiting lead broken by NUL; the rest passes as is.
		record_bytes = '{8'hC3, 8'h00, 8'hFF};
		send_record();
		wait_drained();

		rec_idx = 0;
		while (items_sent < ITEM_TARGET) begin
			if (rec_idx == 3)
				hold_go = 1'b1;
			no_idle = (rec_idx >= 12 && rec_idx < 20);
			build_record();
			send_record();
			if (rec_idx == 25)
				wait_drained();
			rec_idx++;
		end
		no_idle = 1'b0;
		wait_drained();
		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
